// ===== hdl/bpa_pkg.sv =====
// Shared types and constants for the bin packing allocator.
package bpa_pkg;

    localparam int DATA_W       = 16;
    localparam int IDX_OUT_W    = 6;
    localparam int CNT_OUT_W    = 7;
    localparam int MAX_BINS_DEF = 64;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [DATA_W-1:0] CAP_RESET = 16'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BIN_CAPACITY = 1'b0,
        REG_FIT_MODE     = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_OVERSIZE = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] left;
    } scan_t;

    // Room update broadcast to the cells
    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] room;
    } wr_t;

endpackage

// ===== hdl/bin_packing_allocator.sv =====
// Top level of the online bin packing allocator: sequencer and the chain of bin cells.
//
// Items enter on the s_ group: item size and a new-job flag. Each item gives one
// result on the m_ group: bin index, new-bin flag and open bin count in m_tdata,
// status in m_tuser (placed, item larger than capacity, no free bin).
// bin_capacity and fit_mode (first or best fit) are to be written on the cfg_ port
// only while the block is idle; the block does not enforce this. Both take effect
// from the next item. A search token enters the first cell after an item is taken and
// moves one cell per cycle; each bin cell compares its room with the item size.
// The result is registered once the token has passed the last cell, and the next item
// is taken only after that, so the length of the cell chain sets the item rate.
// s_tready stays low while an item is in the chain. The result register holds
// until m_tready; a finished search waits for it, so nothing is lost on a stall.
// Reset empties the bin table and restores capacity 255 and first fit; bin rooms
// are written when a bin is opened and need no clearing.
module bin_packing_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int IDX_W   = $clog2(MAX_BINS),
    localparam int CNT_W   = $clog2(MAX_BINS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // item_size[15:0], new_job[16], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // bin_index[5:0], opened_new[6], bins_used[13:7]
    output logic [1:0]            m_tuser,   // status[1:0]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata
);

    logic [IDX_OUT_W-1:0] bin_index;
    logic                 opened_new;
    logic [CNT_OUT_W-1:0] bins_used;
    logic [1:0]           status;
    logic [DATA_W-1:0]    size;
    logic                 fit_mode;
    logic [CNT_W-1:0]     open_count;
    wr_t                  wr;
    logic [IDX_W-1:0]     wr_idx;
    scan_t                tok_chain [MAX_BINS+1];
    logic [IDX_W-1:0]     idx_chain [MAX_BINS+1];

    bpa_ctrl #(
        .MAX_BINS (MAX_BINS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item_size  (s_tdata[15:0]),
        .new_job    (s_tdata[16]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .bin_index  (bin_index),
        .opened_new (opened_new),
        .bins_used  (bins_used),
        .status     (status),
        .size       (size),
        .fit_mode   (fit_mode),
        .open_count (open_count),
        .wr         (wr),
        .wr_idx     (wr_idx),
        .tok_end    (tok_chain[MAX_BINS]),
        .idx_end    (idx_chain[MAX_BINS])
    );

    assign tok_chain[0] = '0;
    assign idx_chain[0] = '0;

    for (genvar i = 0; i < MAX_BINS; i++)
    begin : g_cell
        bpa_cell #(
            .MAX_BINS (MAX_BINS),
            .J        (i)
        ) u_cell (
            .clk        (clk),
            .size       (size),
            .fit_mode   (fit_mode),
            .open_count (open_count),
            .wr         (wr),
            .wr_idx     (wr_idx),
            .tok_in     (tok_chain[i]),
            .idx_in     (idx_chain[i]),
            .tok_out    (tok_chain[i+1]),
            .idx_out    (idx_chain[i+1])
        );
    end

    assign m_tdata = {2'b00, bins_used, opened_new, bin_index};
    assign m_tuser = status;

endmodule

// ===== hdl/bpa_cell.sv =====
// One bin cell: holds the room of one bin and refines the passing search token.
module bpa_cell
    import bpa_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF,
    parameter int J        = 0,
    localparam int IDX_W   = $clog2(MAX_BINS),
    localparam int CNT_W   = $clog2(MAX_BINS + 1)
)
(
    input  logic              clk,
    input  logic [DATA_W-1:0] size,
    input  logic              fit_mode,
    input  logic [CNT_W-1:0]  open_count,
    input  wr_t               wr,
    input  logic [IDX_W-1:0]  wr_idx,
    input  scan_t             tok_in,
    input  logic [IDX_W-1:0]  idx_in,
    output scan_t             tok_out,
    output logic [IDX_W-1:0]  idx_out
);

    logic [DATA_W-1:0] room_reg;
    scan_t             tok_reg;
    scan_t             tok_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              is_open;
    logic              fits;
    logic              take;
    logic [DATA_W-1:0] left;

    always_comb
    begin
        is_open  = CNT_W'(J) < open_count;
        fits     = is_open && (room_reg >= size);
        left     = room_reg - size;
        // first fit keeps the earliest hit; best fit only moves on a strictly tighter fit
        take     = fits && (!tok_in.found || (fit_mode && (left < tok_in.left)));
        tok_next = tok_in;
        idx_next = idx_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.left  = left;
            idx_next       = IDX_W'(J);
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        idx_reg <= idx_next;
        if (wr.en && (wr_idx == IDX_W'(J)))
        begin
            room_reg <= wr.room;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

// ===== hdl/bpa_ctrl.sv =====
// Sequencer: takes items, waits out the cell chain, updates the bins and holds the result.
module bpa_ctrl
    import bpa_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int IDX_W   = $clog2(MAX_BINS),
    localparam int CNT_W   = $clog2(MAX_BINS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     item_size,
    input  logic                  new_job,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [IDX_OUT_W-1:0]  bin_index,
    output logic                  opened_new,
    output logic [CNT_OUT_W-1:0]  bins_used,
    output logic [1:0]            status,
    output logic [DATA_W-1:0]     size,
    output logic                  fit_mode,
    output logic [CNT_W-1:0]      open_count,
    output wr_t                   wr,
    output logic [IDX_W-1:0]      wr_idx,
    input  scan_t                 tok_end,
    input  logic [IDX_W-1:0]      idx_end
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BINS);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DATA_W-1:0]    size_reg, size_next;
    logic                 over_reg, over_next;
    logic [DATA_W-1:0]    cap_reg;
    logic                 mode_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0] idx_reg, idx_next;
    logic                 opened_reg, opened_next;
    logic [CNT_OUT_W-1:0] used_reg, used_next;
    status_t              status_reg, status_next;
    logic                 finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            mode_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BIN_CAPACITY: cap_reg  <= cfg_wdata;
                    REG_FIT_MODE:     mode_reg <= cfg_wdata[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        over_reg   <= over_next;
        idx_reg    <= idx_next;
        opened_reg <= opened_next;
        used_reg   <= used_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        over_next      = over_reg;
        out_valid_next = out_valid_reg && !m_tready;
        idx_next       = idx_reg;
        opened_next    = opened_reg;
        used_next      = used_reg;
        status_next    = status_reg;
        wr             = '0;
        wr_idx         = '0;
        finish         = 1'b0;
        s_tready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    size_next  = item_size;
                    over_next  = item_size > cap_reg;
                    if (new_job)
                    begin
                        count_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != MAX_CNT)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // token at the end of the chain has seen every cell
                    finish         = 1'b1;
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    idx_next       = '0;
                    opened_next    = 1'b0;
                    status_next    = ST_PLACED;
                    if (over_reg)
                    begin
                        status_next = ST_OVERSIZE;
                    end
                    else if (tok_end.found)
                    begin
                        wr.en    = 1'b1;
                        wr.room  = tok_end.left;
                        wr_idx   = idx_end;
                        idx_next = IDX_OUT_W'(idx_end);
                    end
                    else if (count_reg >= MAX_CNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr.en       = 1'b1;
                        wr.room     = cap_reg - size_reg;
                        wr_idx      = count_reg[IDX_W-1:0];
                        idx_next    = IDX_OUT_W'(count_reg);
                        opened_next = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    used_next = CNT_OUT_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign bin_index  = idx_reg;
    assign opened_new = opened_reg;
    assign bins_used  = used_reg;
    assign status     = status_reg;
    assign size       = size_reg;
    assign fit_mode   = mode_reg;
    assign open_count = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("open bin count beyond table size");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("scan counter overrun");

    a_open_incr: assert property (@(posedge clk) disable iff (!rst_n)
        finish && opened_next |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("new bin opened without count step");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_PLACED) |-> (idx_reg == '0) && !opened_reg)
        else $error("rejected item carries a bin");

endmodule
